### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, quiet during reset.
`define AST_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, clocked on i_clk, quiet during reset.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/fcsq_pkg.sv
// ----------------------------------------------------------------------------
// fcsq_pkg
// Word types, opcodes and fixed constants of the fill colour quantiser.
// ----------------------------------------------------------------------------
package fcsq_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_PAL   = 2'd0,
        OP_LOAD_SHADE = 2'd1,
        OP_QUANTIZE   = 2'd2,
        OP_RESERVED   = 2'd3
    } t_opcode;

    localparam logic [15:0] FULL_SCALE = 16'hFFFF;
    localparam logic [16:0] LEVEL_SPAN = 17'h0FFFE;
    localparam logic [16:0] HALF_SPAN  = 17'h07FFF;
    localparam logic [16:0] SHADE_ONE  = 17'h10000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  entry_index;
        logic [15:0] pen_red;
        logic [15:0] pen_green;
        logic [15:0] pen_blue;
        logic [15:0] fill_red;
        logic [15:0] fill_green;
        logic [15:0] fill_blue;
        logic [15:0] fill_amount;
        logic [16:0] shade_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0] pen_index;
        logic [3:0] background_index;
        logic [2:0] shading_index;
        logic       fill_active;
    } t_out_item;

endpackage

### hw/rtl/fill_color_shading_quantizer_top.sv
// ----------------------------------------------------------------------------
// fill_color_shading_quantizer_top
// Nearest-palette pen match, then a background/shading pair search for fill.
// ----------------------------------------------------------------------------
//  channel | handshake              | word
//  --------+------------------------+---------------------------------------
//  command | start high, busy low   | i_item  (t_in_item: load or quantize)
//  result  | o_done for one cycle   | o_result (t_out_item), receiver cannot stall
//
//  Loads write a RAM at the accepting edge and leave busy low.
//  A quantize holds busy for the pen scan, then with fill for desaturation, for the
//  fetch of the pen entry and for the pair scan, which tests one background/shading
//  pair per cycle. o_done pulses as busy drops; without fill it ends after the pen
//  scan. Reset is synchronous and clears control only; results are never stalled.
// ----------------------------------------------------------------------------
module fill_color_shading_quantizer_top
    import fcsq_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 16,
    parameter int SHADING_ENTRIES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output t_out_item o_result,
    output logic      o_done
);
    localparam int PAW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int SAW = (SHADING_ENTRIES > 1) ? $clog2(SHADING_ENTRIES) : 1;
    localparam logic [PAW-1:0] LAST_P = PAW'(PALETTE_ENTRIES - 1);
    localparam logic [SAW-1:0] LAST_S = SAW'(SHADING_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PEN, S_PWAIT, S_DMUL, S_DSUM, S_DDIV,
        S_PREAD, S_PLATCH, S_FILL, S_FWAIT
    } t_state;

    t_state    r_state;
    logic      r_busy, r_done;
    t_out_item r_result;
    logic [PAW-1:0] r_ci, r_bi;
    logic [SAW-1:0] r_sj;
    logic [PAW-1:0] r_pen;
    t_in_item       r_item;

    // ---- command decode and RAM writes --------------------------------------
    logic accept;
    logic [8:0] idx9;
    logic pal_we, sh_we;
    logic [16:0] shade_sat;
    assign accept    = start && !r_busy;
    assign idx9      = 9'(i_item.entry_index);
    assign pal_we    = accept && (i_item.opcode == OP_LOAD_PAL)
                       && (idx9 < 9'(PALETTE_ENTRIES));
    assign sh_we     = accept && (i_item.opcode == OP_LOAD_SHADE)
                       && (idx9 < 9'(SHADING_ENTRIES));
    // clamp fractions above 1.0
    assign shade_sat = (i_item.shade_value > SHADE_ONE) ? SHADE_ONE : i_item.shade_value;

    logic [PAW-1:0] pal_raddr;
    logic [47:0]    rd_pal;
    logic [16:0]    rd_sh;

    always_comb begin
        case (r_state)
            S_PEN:   pal_raddr = r_ci;
            S_PREAD: pal_raddr = r_pen;
            default: pal_raddr = r_bi;
        endcase
    end

    fcsq_ram #(.WIDTH(48), .DEPTH(PALETTE_ENTRIES)) u_pal (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (idx9[PAW-1:0]),
        .i_wdata ({i_item.pen_red, i_item.pen_green, i_item.pen_blue}),
        .i_raddr (pal_raddr),
        .o_rdata (rd_pal)
    );

    fcsq_ram #(.WIDTH(17), .DEPTH(SHADING_ENTRIES)) u_shade (
        .i_clk   (i_clk),
        .i_we    (sh_we),
        .i_waddr (idx9[SAW-1:0]),
        .i_wdata (shade_sat),
        .i_raddr (r_sj),
        .o_rdata (rd_sh)
    );

    // split RAM and item words into red, green, blue lanes
    logic [2:0][15:0] pal_c, pen_c, fill_c;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pal_c[k] = rd_pal[47-16*k -: 16];
        end
        pen_c  = {r_item.pen_blue, r_item.pen_green, r_item.pen_red};
        fill_c = {r_item.fill_blue, r_item.fill_green, r_item.fill_red};
    end

    // ---- pen scan pipeline: read, diff, square, compare ---------------------
    logic             r_pv1, r_pv2, r_pv3;
    logic [PAW-1:0]   r_pi1, r_pi2, r_pi3;
    logic [2:0][15:0] r_pd;
    logic [2:0][31:0] r_psq;
    logic [33:0]      r_pbest;
    logic [33:0]      pen_sum;

    assign pen_sum = 34'(r_psq[0]) + 34'(r_psq[1]) + 34'(r_psq[2]);

    always_ff @(posedge i_clk) begin
        r_pi1 <= r_ci;
        r_pi2 <= r_pi1;
        r_pi3 <= r_pi2;
        for (int k = 0; k < 3; k++) begin
            r_pd[k]  <= (pal_c[k] > pen_c[k]) ? pal_c[k] - pen_c[k] : pen_c[k] - pal_c[k];
            r_psq[k] <= r_pd[k] * r_pd[k];
        end
        // lowest index wins a tie: replace only on strictly smaller
        if (r_pv3 && ((r_pi3 == '0) || (pen_sum < r_pbest))) begin
            r_pbest <= pen_sum;
            r_pen   <= r_pi3;
        end
    end

    // ---- desaturation toward white, divide by 65534 -------------------------
    // n = hi*65536 + lo = hi*65534 + (2*hi + lo); the fold 2*hi + lo stays
    // below three spans, so two compares finish the quotient.
    logic [2:0][31:0] r_m1, r_m2;
    logic [2:0][17:0] r_fold;
    logic [2:0][15:0] r_quo;
    logic [2:0][31:0] dnum;
    logic [2:0][1:0]  dinc;
    logic [15:0]      lvl_m1;

    assign lvl_m1 = r_item.fill_amount - 16'd1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dnum[k] = r_m1[k] + r_m2[k] + 32'(HALF_SPAN);
            dinc[k] = (r_fold[k] >= {LEVEL_SPAN, 1'b0}) ? 2'd2 :
                      (r_fold[k] >= 18'(LEVEL_SPAN))    ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (r_state == S_DMUL) begin
                r_m1[k] <= fill_c[k] * LEVEL_SPAN[15:0];
                r_m2[k] <= lvl_m1 * (FULL_SCALE - fill_c[k]);
            end
            if (r_state == S_DSUM) begin
                r_quo[k]  <= dnum[k][31:16];
                r_fold[k] <= {1'b0, dnum[k][31:16], 1'b0} + 18'(dnum[k][15:0]);
            end else if (r_state == S_DDIV) begin
                r_quo[k] <= r_quo[k] + 16'(dinc[k]);
            end
        end
    end

    // ---- pair scan pipeline: read, blend products, error, square, compare ---
    logic [2:0][15:0] r_penc;
    logic             r_fv1, r_fv2, r_fv3, r_fv4;
    logic [PAW-1:0]   r_fb1, r_fb2, r_fb3, r_fb4;
    logic [SAW-1:0]   r_fs1, r_fs2, r_fs3, r_fs4;
    logic [2:0][32:0] r_fa, r_fbp;
    logic [2:0][31:0] r_fd;
    logic [2:0][63:0] r_fsq;
    logic [65:0]      r_fbest;
    logic [PAW-1:0]   r_bgi;
    logic [SAW-1:0]   r_shi;
    logic [65:0]      fill_sum;
    logic [2:0][31:0] got, want;
    logic [16:0]      shade_inv;

    assign shade_inv = SHADE_ONE - rd_sh;
    assign fill_sum  = 66'(r_fsq[0]) + 66'(r_fsq[1]) + 66'(r_fsq[2]);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            got[k]  = 32'(r_fa[k] + r_fbp[k]);
            want[k] = {r_quo[k], 16'h0000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PLATCH) begin
            r_penc <= pal_c;
        end
        r_fb1 <= r_bi;
        r_fs1 <= r_sj;
        r_fb2 <= r_fb1;
        r_fs2 <= r_fs1;
        r_fb3 <= r_fb2;
        r_fs3 <= r_fs2;
        r_fb4 <= r_fb3;
        r_fs4 <= r_fs3;
        for (int k = 0; k < 3; k++) begin
            r_fa[k]  <= rd_sh * pal_c[k];
            r_fbp[k] <= shade_inv * r_penc[k];
            r_fd[k]  <= (want[k] > got[k]) ? want[k] - got[k] : got[k] - want[k];
            r_fsq[k] <= r_fd[k] * r_fd[k];
        end
        // first pair reached wins a tie
        if (r_fv4 && (((r_fb4 == '0) && (r_fs4 == '0)) || (fill_sum < r_fbest))) begin
            r_fbest <= fill_sum;
            r_bgi   <= r_fb4;
            r_shi   <= r_fs4;
        end
    end

    // ---- pipeline valid bits ------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_pv1, r_pv2, r_pv3} <= '0;
            {r_fv1, r_fv2, r_fv3, r_fv4} <= '0;
        end else begin
            r_pv1 <= (r_state == S_PEN);
            r_pv2 <= r_pv1;
            r_pv3 <= r_pv2;
            r_fv1 <= (r_state == S_FILL);
            r_fv2 <= r_fv1;
            r_fv3 <= r_fv2;
            r_fv4 <= r_fv3;
        end
    end

    // ---- sequencer ----------------------------------------------------------
    logic [8:0] pen9, bg9, sh9;
    assign pen9 = 9'(r_pen);
    assign bg9  = 9'(r_bgi);
    assign sh9  = 9'(r_shi);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_ci    <= '0;
            r_bi    <= '0;
            r_sj    <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_item.opcode == OP_QUANTIZE)) begin
                        r_state <= S_PEN;
                        r_busy  <= 1'b1;
                        r_ci    <= '0;
                    end
                end
                S_PEN: begin
                    r_ci <= r_ci + 1'b1;
                    if (r_ci == LAST_P) begin
                        r_state <= S_PWAIT;
                    end
                end
                S_PWAIT: begin
                    // hold until the last pen candidate is compared
                    if (!r_pv1 && !r_pv2 && !r_pv3) begin
                        if (r_item.fill_amount == '0) begin
                            r_result <= '{pen_index: pen9[3:0], background_index: 4'd0,
                                          shading_index: 3'd0, fill_active: 1'b0};
                            r_done   <= 1'b1;
                            r_busy   <= 1'b0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_DMUL;
                        end
                    end
                end
                S_DMUL: r_state <= S_DSUM;
                S_DSUM: r_state <= S_DDIV;
                S_DDIV: r_state <= S_PREAD;
                S_PREAD: r_state <= S_PLATCH;
                S_PLATCH: begin
                    r_bi    <= '0;
                    r_sj    <= '0;
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    // shading is the inner loop, background the outer
                    if (r_sj == LAST_S) begin
                        r_sj <= '0;
                        r_bi <= r_bi + 1'b1;
                        if (r_bi == LAST_P) begin
                            r_state <= S_FWAIT;
                        end
                    end else begin
                        r_sj <= r_sj + 1'b1;
                    end
                end
                S_FWAIT: begin
                    if (!r_fv1 && !r_fv2 && !r_fv3 && !r_fv4) begin
                        r_result <= '{pen_index: pen9[3:0], background_index: bg9[3:0],
                                      shading_index: sh9[2:0], fill_active: 1'b1};
                        r_done   <= 1'b1;
                        r_busy   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;
endmodule

### hw/rtl/fcsq_ram.sv
// ----------------------------------------------------------------------------
// fcsq_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fcsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/fcsq_checker.sv
// ----------------------------------------------------------------------------
// fcsq_checker
// Port-level timing checks of the quantiser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcsq_checker
    import fcsq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_item,
    input t_out_item o_result,
    input logic      o_done
);
    `AST_SAME(a_done_not_busy, o_done, !busy)
    `AST_NEXT(a_quant_goes_busy, start && !busy && (i_item.opcode == OP_QUANTIZE), busy)
    `AST_NEXT(a_load_stays_idle, start && !busy && (i_item.opcode != OP_QUANTIZE), !busy && !o_done)
    `AST_SAME(a_busy_ends_in_word, $fell(busy), o_done)
    `AST_SAME(a_no_fill_zero, o_done && !o_result.fill_active,
              (o_result.background_index == 4'd0) && (o_result.shading_index == 3'd0))
endmodule

bind fill_color_shading_quantizer_top fcsq_checker u_fcsq_checker (.*);

### sim/fill_color_shading_quantizer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fill_color_shading_quantizer_top_tb
// Self-checking bench: loads palette and shading tables, sends quantize
// commands, predicts pen, background and shading indices, compares each word.
// ----------------------------------------------------------------------------
module fill_color_shading_quantizer_top_tb;
    import fcsq_pkg::*;

    localparam int NUM_PAL     = 16;
    localparam int NUM_SHADE   = 8;
    localparam int WDOG_LIMIT  = 20000;
    localparam int DRAIN_TICKS = 200;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    t_out_item o_result;
    logic      o_done;

    // Shadow copy of the block's tables, kept by the predictor
    logic [15:0] pal_r [NUM_PAL];
    logic [15:0] pal_g [NUM_PAL];
    logic [15:0] pal_b [NUM_PAL];
    logic [16:0] shade_tab [NUM_SHADE];

    t_out_item   expected_q[$];
    int          err_count;
    int          idle_pct;
    int          quiet_ticks;

    fill_color_shading_quantizer_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_result (o_result),
        .o_done   (o_done)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // Desaturate one component toward white, rounding halves up
    function automatic logic [15:0] toward_white(input logic [15:0] c,
                                                 input logic [15:0] lvl);
        logic [63:0] num;
        num = 64'(c) * 64'hFFFE + 64'(lvl - 16'd1) * 64'(16'hFFFF - c);
        return 16'((num + 64'h7FFF) / 64'hFFFE);
    endfunction

    function automatic logic [65:0] blend_sq(input logic [15:0] tgt,
                                             input logic [15:0] bg,
                                             input logic [15:0] pn,
                                             input logic [16:0] s);
        logic [63:0] want;
        logic [63:0] got;
        logic [65:0] d;
        want = 64'(tgt) * 64'h10000;
        got  = 64'(s) * 64'(bg) + (64'h10000 - 64'(s)) * 64'(pn);
        d    = (want > got) ? 66'(want - got) : 66'(got - want);
        return d * d;
    endfunction

    // Work out the result word of one quantize command
    function automatic t_out_item quantize_colours(input t_in_item it);
        t_out_item   res;
        logic [63:0] pen_err;
        logic [63:0] best;
        logic [65:0] err;
        logic [65:0] best_err;
        logic [15:0] tr, tg, tb;
        logic [31:0] dr, dg, db;
        int          pen;
        res  = '0;
        pen  = 0;
        best = '0;
        for (int i = 0; i < NUM_PAL; i++) begin
            dr = (pal_r[i] > it.pen_red)   ? pal_r[i] - it.pen_red   : it.pen_red - pal_r[i];
            dg = (pal_g[i] > it.pen_green) ? pal_g[i] - it.pen_green : it.pen_green - pal_g[i];
            db = (pal_b[i] > it.pen_blue)  ? pal_b[i] - it.pen_blue  : it.pen_blue - pal_b[i];
            pen_err = 64'(dr) * dr + 64'(dg) * dg + 64'(db) * db;
            if (i == 0 || pen_err < best) begin
                best = pen_err;
                pen  = i;
            end
        end
        res.pen_index = 4'(pen);
        if (it.fill_amount != 16'd0) begin
            tr = toward_white(it.fill_red, it.fill_amount);
            tg = toward_white(it.fill_green, it.fill_amount);
            tb = toward_white(it.fill_blue, it.fill_amount);
            res.fill_active = 1'b1;
            best_err = '1;
            for (int i = 0; i < NUM_PAL; i++) begin
                for (int j = 0; j < NUM_SHADE; j++) begin
                    err = blend_sq(tr, pal_r[i], pal_r[pen], shade_tab[j])
                        + blend_sq(tg, pal_g[i], pal_g[pen], shade_tab[j])
                        + blend_sq(tb, pal_b[i], pal_b[pen], shade_tab[j]);
                    if ((i == 0 && j == 0) || err < best_err) begin
                        best_err = err;
                        res.background_index = 4'(i);
                        res.shading_index    = 3'(j);
                    end
                end
            end
        end
        return res;
    endfunction

    // Update the shadow tables and queue any expected word
    function automatic void predict(input t_in_item it);
        case (it.opcode)
            OP_LOAD_PAL: begin
                pal_r[it.entry_index] = it.pen_red;
                pal_g[it.entry_index] = it.pen_green;
                pal_b[it.entry_index] = it.pen_blue;
            end
            OP_LOAD_SHADE: begin
                if (it.entry_index < NUM_SHADE)
                    shade_tab[it.entry_index[2:0]] =
                        (it.shade_value > SHADE_ONE) ? SHADE_ONE : it.shade_value;
            end
            OP_QUANTIZE: begin
                expected_q.push_back(quantize_colours(it));
            end
            default: begin
            end
        endcase
    endfunction

    // Send one command word; hold start until the block takes it
    task automatic send_word(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict(it);
    endtask

    function automatic t_in_item rand_word(input logic [1:0] op);
        t_in_item it;
        it             = '0;
        it.opcode      = op;
        it.entry_index = 4'($urandom);
        it.pen_red     = 16'($urandom);
        it.pen_green   = 16'($urandom);
        it.pen_blue    = 16'($urandom);
        it.fill_red    = 16'($urandom);
        it.fill_green  = 16'($urandom);
        it.fill_blue   = 16'($urandom);
        it.fill_amount = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
        it.shade_value = ($urandom_range(3) == 0) ? 17'($urandom) :
                         17'($urandom_range(65536));
        return it;
    endfunction

    // Fill every entry so that no quantize ever reads an unwritten one
    task automatic test_table_fill();
        t_in_item it;
        for (int i = 0; i < NUM_PAL; i++) begin
            it = rand_word(OP_LOAD_PAL);
            it.entry_index = 4'(i);
            if (i == 0) begin
                it.pen_red = 16'h0000; it.pen_green = 16'h0000; it.pen_blue = 16'h0000;
            end else if (i == 1) begin
                it.pen_red = 16'hFFFF; it.pen_green = 16'hFFFF; it.pen_blue = 16'hFFFF;
            end
            send_word(it);
        end
        for (int j = 0; j < NUM_SHADE; j++) begin
            it = rand_word(OP_LOAD_SHADE);
            it.entry_index = 4'(j);
            it.shade_value = (j == 0) ? 17'd0 : (j == 1) ? SHADE_ONE : it.shade_value;
            send_word(it);
        end
    endtask

    // Extremes, no fill, full colour, white, ties, ignored loads, unused opcode
    task automatic test_directed();
        t_in_item it;
        it = rand_word(OP_QUANTIZE);
        it.pen_red = '0; it.pen_green = '0; it.pen_blue = '0;
        it.fill_amount = 16'd0;
        send_word(it);
        it = rand_word(OP_QUANTIZE);
        it.pen_red = '1; it.pen_green = '1; it.pen_blue = '1;
        it.fill_red = '0; it.fill_green = '0; it.fill_blue = '0;
        it.fill_amount = 16'd1;
        send_word(it);
        it.fill_red = '1; it.fill_green = '1; it.fill_blue = '1;
        it.fill_amount = 16'hFFFF;
        send_word(it);
        it.fill_amount = 16'h8000;
        send_word(it);
        // Out-of-range shading load: dropped
        it = rand_word(OP_LOAD_SHADE);
        it.entry_index = 4'd12;
        send_word(it);
        // Oversized shade value saturates
        it = rand_word(OP_LOAD_SHADE);
        it.entry_index = 4'd2;
        it.shade_value = 17'h1FFFF;
        send_word(it);
        // Duplicate palette entry: lowest index wins ties
        it = rand_word(OP_LOAD_PAL);
        it.entry_index = 4'd15;
        it.pen_red = '1; it.pen_green = '1; it.pen_blue = '1;
        send_word(it);
        it = rand_word(OP_QUANTIZE);
        it.pen_red = '1; it.pen_green = '1; it.pen_blue = '1;
        send_word(it);
        it = rand_word(OP_RESERVED);
        send_word(it);
        it = rand_word(OP_QUANTIZE);
        send_word(it);
    endtask

    // Mostly quantize commands, table reloads mixed in
    task automatic test_random(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_word(rand_word(OP_QUANTIZE));
            else if (pick < 78)
                send_word(rand_word(OP_LOAD_PAL));
            else if (pick < 95)
                send_word(rand_word(OP_LOAD_SHADE));
            else
                send_word(rand_word(OP_RESERVED));
        end
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_word;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                exp_word = expected_q.pop_front();
                if (o_result.pen_index !== exp_word.pen_index)
                    report_mismatch($sformatf("pen_index %0d, want %0d",
                                              o_result.pen_index, exp_word.pen_index));
                if (o_result.background_index !== exp_word.background_index)
                    report_mismatch($sformatf("background_index %0d, want %0d",
                                    o_result.background_index, exp_word.background_index));
                if (o_result.shading_index !== exp_word.shading_index)
                    report_mismatch($sformatf("shading_index %0d, want %0d",
                                    o_result.shading_index, exp_word.shading_index));
                if (o_result.fill_active !== exp_word.fill_active)
                    report_mismatch($sformatf("fill_active %0d, want %0d",
                                    o_result.fill_active, exp_word.fill_active));
            end
        end
    end

    // Watchdog: count cycles in which no word moves either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            quiet_ticks <= 0;
        else
            quiet_ticks <= quiet_ticks + 1;
        if (quiet_ticks >= WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int wait_ticks;
        err_count   = 0;
        idle_pct    = 0;
        quiet_ticks = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_fill();
        test_directed();
        idle_pct = 0;
        test_random(130);
        idle_pct = 79;
        test_random(130);
        idle_pct = 6;
        test_random(130);
        start <= 1'b0;

        // Drain, then allow the block's latency to pass
        wait_ticks = 0;
        while (expected_q.size() != 0 && wait_ticks < WDOG_LIMIT) begin
            @(posedge i_clk);
            wait_ticks++;
        end
        repeat (DRAIN_TICKS) @(posedge i_clk);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (expected_q.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/fcsq_pkg.sv
hw/rtl/fcsq_ram.sv
hw/rtl/fill_color_shading_quantizer_top.sv
hw/rtl/fcsq_checker.sv
sim/fill_color_shading_quantizer_top_tb.sv
